// ===== rtl/core/nfvr_pkg.sv =====
// shared types and constants for the normal frame vector rotator
package nfvr_pkg;

    localparam int VEC_W   = 32;
    localparam int NORM_W  = 32;
    localparam int NORM_FB = 30;
    localparam int RAD_W   = 2 * NORM_W;
    localparam int ROOT_W  = NORM_W;
    localparam int QUO_W   = NORM_FB + 1;
    localparam int COEF_W  = NORM_W + 1;
    localparam int PROD_W  = COEF_W + VEC_W;
    localparam int RND_W   = PROD_W - NORM_FB;
    localparam int TERM_W  = RND_W + 1;
    localparam int SUM_W   = TERM_W + 2;
    localparam int LIMIT_W = 31;
    localparam int CFG_W   = 32;

    typedef enum logic [1:0] {
        DIM_NONE  = 2'd0,
        DIM_ONE   = 2'd1,
        DIM_TWO   = 2'd2,
        DIM_THREE = 2'd3
    } t_dim;

    typedef enum logic {
        OP_FWD  = 1'b0,
        OP_BACK = 1'b1
    } t_op;

    typedef enum logic {
        CFG_DIMENSION = 1'b0,
        CFG_LIMIT     = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_op                      op;
        logic signed [VEC_W-1:0]  ax;
        logic signed [VEC_W-1:0]  ay;
        logic signed [VEC_W-1:0]  az;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
    } t_item;

    typedef struct packed {
        logic                     en;
        logic                     neg;
        logic signed [COEF_W-1:0] coef;
        logic signed [VEC_W-1:0]  vec;
    } t_term;

endpackage

// ===== rtl/core/nfvr_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module nfvr_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [nfvr_pkg::RAD_W-1:0]  i_rad,
    input  nfvr_pkg::t_item             i_item,
    output logic                        o_valid,
    output logic [nfvr_pkg::ROOT_W-1:0] o_root,
    output nfvr_pkg::t_item             o_item
);
    import nfvr_pkg::*;

    logic              r_valid [0:ROOT_W];
    logic [RAD_W-1:0]  r_rad   [0:ROOT_W-1];
    logic [ROOT_W:0]   r_rem   [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root  [0:ROOT_W];
    t_item             r_item  [0:ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
        end
        r_rad[0]  <= i_rad;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_item[0] <= i_item;
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [ROOT_W+2:0] n_shift;
        logic [ROOT_W+2:0] n_trial;
        logic [ROOT_W+2:0] n_diff;
        logic              n_ge;

        assign n_shift = {r_rem[k][ROOT_W:0], r_rad[k][RAD_W-1 -: 2]};
        assign n_trial = {1'b0, r_root[k], 2'b01};
        assign n_ge    = (n_shift >= n_trial);
        assign n_diff  = n_ge ? (n_shift - n_trial) : n_shift;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else begin
                r_valid[k+1] <= r_valid[k];
            end
            r_root[k+1] <= {r_root[k][ROOT_W-2:0], n_ge};
            r_item[k+1] <= r_item[k];
        end

        if (k + 1 < ROOT_W) begin : g_rad
            always_ff @(posedge i_clk) begin
                r_rad[k+1] <= {r_rad[k][RAD_W-3:0], 2'b00};
                r_rem[k+1] <= n_diff[ROOT_W:0];
            end
        end
    end

    assign o_valid = r_valid[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_item  = r_item[ROOT_W];

endmodule

// ===== rtl/core/nfvr_div.sv =====
// two lane pipelined restoring divider for the in-plane direction cosines
module nfvr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [nfvr_pkg::ROOT_W-1:0] i_den,
    input  logic [nfvr_pkg::NORM_W-1:0] i_mag_a,
    input  logic [nfvr_pkg::NORM_W-1:0] i_mag_b,
    input  nfvr_pkg::t_item             i_item,
    output logic                        o_valid,
    output logic [nfvr_pkg::ROOT_W-1:0] o_den,
    output logic [nfvr_pkg::QUO_W-1:0]  o_quo_a,
    output logic [nfvr_pkg::QUO_W-1:0]  o_quo_b,
    output nfvr_pkg::t_item             o_item
);
    import nfvr_pkg::*;

    logic              r_valid [0:QUO_W];
    logic [ROOT_W-1:0] r_den   [0:QUO_W];
    logic [ROOT_W:0]   r_rem_a [0:QUO_W-1];
    logic [ROOT_W:0]   r_rem_b [0:QUO_W-1];
    logic [QUO_W-1:0]  r_quo_a [0:QUO_W];
    logic [QUO_W-1:0]  r_quo_b [0:QUO_W];
    t_item             r_item  [0:QUO_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
        end
        r_den[0]   <= i_den;
        r_rem_a[0] <= {1'b0, i_mag_a};
        r_rem_b[0] <= {1'b0, i_mag_b};
        r_quo_a[0] <= '0;
        r_quo_b[0] <= '0;
        r_item[0]  <= i_item;
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [ROOT_W:0] n_den;
        logic [ROOT_W:0] n_diff_a;
        logic [ROOT_W:0] n_diff_b;
        logic            n_ge_a;
        logic            n_ge_b;

        assign n_den    = {1'b0, r_den[k]};
        assign n_ge_a   = (r_rem_a[k] >= n_den);
        assign n_ge_b   = (r_rem_b[k] >= n_den);
        assign n_diff_a = n_ge_a ? (r_rem_a[k] - n_den) : r_rem_a[k];
        assign n_diff_b = n_ge_b ? (r_rem_b[k] - n_den) : r_rem_b[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else begin
                r_valid[k+1] <= r_valid[k];
            end
            r_den[k+1]   <= r_den[k];
            r_quo_a[k+1] <= {r_quo_a[k][QUO_W-2:0], n_ge_a};
            r_quo_b[k+1] <= {r_quo_b[k][QUO_W-2:0], n_ge_b};
            r_item[k+1]  <= r_item[k];
        end

        if (k + 1 < QUO_W) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem_a[k+1] <= {n_diff_a[ROOT_W-1:0], 1'b0};
                r_rem_b[k+1] <= {n_diff_b[ROOT_W-1:0], 1'b0};
            end
        end
    end

    assign o_valid = r_valid[QUO_W];
    assign o_den   = r_den[QUO_W];
    assign o_quo_a = r_quo_a[QUO_W];
    assign o_quo_b = r_quo_b[QUO_W];
    assign o_item  = r_item[QUO_W];

endmodule

// ===== rtl/core/normal_frame_vector_rotator.sv =====
// top level of the normal frame vector rotator
//
// one vector and one face normal go in with a start beat whenever busy is
// low; busy never rises, so a new beat may follow in every cycle.
// each beat gives exactly one result beat, marked by o_valid for one cycle;
// results leave in the order of the beats.
// one beat per cycle is sustained; the pipeline runs through the 32 stage
// square root for the in-plane normal length followed by the 31 stage
// divider for the direction cosines, one result bit per stage each.
// the receiver has no way to hold results off and none is needed.
// configuration (dimension, near axis limit) is written on its own
// valid/ready channel, always ready, and must be written only while no
// beat is in flight.
// synchronous active low reset empties the pipeline and sets dimension 3
// and limit 11; data registers are not cleared.
module normal_frame_vector_rotator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic                         i_opcode,
    input  logic signed [31:0]           i_vec_x,
    input  logic signed [31:0]           i_vec_y,
    input  logic signed [31:0]           i_vec_z,
    input  logic signed [31:0]           i_norm_x,
    input  logic signed [31:0]           i_norm_y,
    input  logic signed [31:0]           i_norm_z,
    output logic                         o_valid,
    output logic signed [31:0]           o_out_x,
    output logic signed [31:0]           o_out_y,
    output logic signed [31:0]           o_out_z,
    output logic                         o_saturated,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [nfvr_pkg::CFG_W-1:0]   i_cfg_data
);
    import nfvr_pkg::*;

    localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) << (NORM_FB - 1);
    localparam logic signed [SUM_W-1:0]  SAT_HI = SUM_W'((64'(1) << (VEC_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0]  SAT_LO = -SAT_HI - SUM_W'(1);

    // configuration
    t_dim               r_dim;
    logic [LIMIT_W-1:0] r_limit;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim   <= DIM_THREE;
            r_limit <= LIMIT_W'(11);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DIMENSION: r_dim   <= t_dim'(i_cfg_data[1:0]);
                CFG_LIMIT:     r_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register and squares
    logic               r_s0_valid;
    t_item              r_s0_item;
    logic               r_s1_valid;
    t_item              r_s1_item;
    logic [RAD_W-2:0]   r_s1_sqx;
    logic [RAD_W-2:0]   r_s1_sqy;
    logic signed [RAD_W-1:0] n_sqx;
    logic signed [RAD_W-1:0] n_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s0_valid <= i_start && !o_busy;
            r_s1_valid <= r_s0_valid;
        end
        r_s0_item <= '{op: t_op'(i_opcode), ax: i_vec_x, ay: i_vec_y, az: i_vec_z,
                       nx: i_norm_x, ny: i_norm_y, nz: i_norm_z};
        r_s1_item <= r_s0_item;
        r_s1_sqx  <= n_sqx[RAD_W-2:0];
        r_s1_sqy  <= n_sqy[RAD_W-2:0];
    end

    assign n_sqx = r_s0_item.nx * r_s0_item.nx;
    assign n_sqy = r_s0_item.ny * r_s0_item.ny;

    // in-plane length
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    t_item             sq_item;

    nfvr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_rad   ({1'b0, r_s1_sqx} + {1'b0, r_s1_sqy}),
        .i_item  (r_s1_item),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_item  (sq_item)
    );

    // direction cosines
    logic              dv_valid;
    logic [ROOT_W-1:0] dv_den;
    logic [QUO_W-1:0]  dv_quo_a;
    logic [QUO_W-1:0]  dv_quo_b;
    t_item             dv_item;
    logic [NORM_W-1:0] n_mag_x;
    logic [NORM_W-1:0] n_mag_y;

    assign n_mag_x = sq_item.nx[NORM_W-1] ? -sq_item.nx : sq_item.nx;
    assign n_mag_y = sq_item.ny[NORM_W-1] ? -sq_item.ny : sq_item.ny;

    nfvr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_den   (sq_root),
        .i_mag_a (n_mag_x),
        .i_mag_b (n_mag_y),
        .i_item  (sq_item),
        .o_valid (dv_valid),
        .o_den   (dv_den),
        .o_quo_a (dv_quo_a),
        .o_quo_b (dv_quo_b),
        .o_item  (dv_item)
    );

    // signed cosines, then cross terms with nz
    logic                     r_c_valid;
    t_item                    r_c_item;
    logic [ROOT_W-1:0]        r_c_den;
    logic                     r_c_far;
    logic signed [NORM_W-1:0] r_c_cx;
    logic signed [NORM_W-1:0] r_c_cy;
    logic [NORM_W-1:0]        n_qx;
    logic [NORM_W-1:0]        n_qy;

    assign n_qx = {1'b0, dv_quo_a};
    assign n_qy = {1'b0, dv_quo_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= dv_valid;
        end
        r_c_item <= dv_item;
        r_c_den  <= dv_den;
        r_c_far  <= (dv_den > {1'b0, r_limit});
        r_c_cx   <= dv_item.nx[NORM_W-1] ? -n_qx : n_qx;
        r_c_cy   <= dv_item.ny[NORM_W-1] ? -n_qy : n_qy;
    end

    logic                     r_e1_valid;
    t_item                    r_e1_item;
    logic [ROOT_W-1:0]        r_e1_den;
    logic                     r_e1_far;
    logic signed [NORM_W-1:0] r_e1_cx;
    logic signed [NORM_W-1:0] r_e1_cy;
    logic signed [RAD_W-1:0]  r_e1_px;
    logic signed [RAD_W-1:0]  r_e1_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_valid <= 1'b0;
        end else begin
            r_e1_valid <= r_c_valid;
        end
        r_e1_item <= r_c_item;
        r_e1_den  <= r_c_den;
        r_e1_far  <= r_c_far;
        r_e1_cx   <= r_c_cx;
        r_e1_cy   <= r_c_cy;
        r_e1_px   <= r_c_cx * r_c_item.nz;
        r_e1_py   <= r_c_cy * r_c_item.nz;
    end

    logic                     r_e2_valid;
    t_item                    r_e2_item;
    logic [ROOT_W-1:0]        r_e2_den;
    logic                     r_e2_far;
    logic signed [NORM_W-1:0] r_e2_cx;
    logic signed [NORM_W-1:0] r_e2_cy;
    logic signed [COEF_W-1:0] r_e2_ex;
    logic signed [COEF_W-1:0] r_e2_ey;
    logic signed [RAD_W-1:0]  n_ex_full;
    logic signed [RAD_W-1:0]  n_ey_full;

    assign n_ex_full = (r_e1_px + RAD_W'(RND)) >>> NORM_FB;
    assign n_ey_full = (r_e1_py + RAD_W'(RND)) >>> NORM_FB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_valid <= 1'b0;
        end else begin
            r_e2_valid <= r_e1_valid;
        end
        r_e2_item <= r_e1_item;
        r_e2_den  <= r_e1_den;
        r_e2_far  <= r_e1_far;
        r_e2_cx   <= r_e1_cx;
        r_e2_cy   <= r_e1_cy;
        r_e2_ex   <= n_ex_full[COEF_W-1:0];
        r_e2_ey   <= n_ey_full[COEF_W-1:0];
    end

    // term selection per component, three terms each
    function automatic t_term mk(input logic neg, input logic signed [COEF_W-1:0] coef,
                                 input logic signed [VEC_W-1:0] vec);
        t_term t;
        t.en   = 1'b1;
        t.neg  = neg;
        t.coef = coef;
        t.vec  = vec;
        return t;
    endfunction

    t_term                    n_term [0:8];
    logic [2:0]               n_pass;
    logic signed [COEF_W-1:0] c_nx;
    logic signed [COEF_W-1:0] c_ny;
    logic signed [COEF_W-1:0] c_nz;
    logic signed [COEF_W-1:0] c_cx;
    logic signed [COEF_W-1:0] c_cy;
    logic signed [COEF_W-1:0] c_d;
    logic                     n_back;

    assign c_nx   = COEF_W'(r_e2_item.nx);
    assign c_ny   = COEF_W'(r_e2_item.ny);
    assign c_nz   = COEF_W'(r_e2_item.nz);
    assign c_cx   = COEF_W'(r_e2_cx);
    assign c_cy   = COEF_W'(r_e2_cy);
    assign c_d    = $signed({1'b0, r_e2_den});
    assign n_back = (r_e2_item.op == OP_BACK);

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n_term[i] = '0;
        end
        n_pass = 3'b111;
        unique case (r_dim)
            DIM_NONE: begin
                n_pass = 3'b111;
            end
            DIM_ONE: begin
                n_pass    = 3'b110;
                n_term[0] = mk(1'b0, c_nx, r_e2_item.ax);
            end
            DIM_TWO: begin
                n_pass    = 3'b100;
                n_term[0] = mk(1'b0, c_nx, r_e2_item.ax);
                n_term[1] = mk(n_back, c_ny, r_e2_item.ay);
                n_term[3] = mk(!n_back, c_ny, r_e2_item.ax);
                n_term[4] = mk(1'b0, c_nx, r_e2_item.ay);
            end
            DIM_THREE: begin
                if (!r_e2_far) begin
                    n_pass    = 3'b010;
                    n_term[0] = mk(n_back, c_nz, r_e2_item.az);
                    n_term[6] = mk(!n_back, c_nz, r_e2_item.ax);
                end else if (!n_back) begin
                    n_pass    = 3'b000;
                    n_term[0] = mk(1'b0, c_nx, r_e2_item.ax);
                    n_term[1] = mk(1'b0, c_ny, r_e2_item.ay);
                    n_term[2] = mk(1'b0, c_nz, r_e2_item.az);
                    n_term[3] = mk(1'b1, c_cy, r_e2_item.ax);
                    n_term[4] = mk(1'b0, c_cx, r_e2_item.ay);
                    n_term[6] = mk(1'b1, r_e2_ex, r_e2_item.ax);
                    n_term[7] = mk(1'b1, r_e2_ey, r_e2_item.ay);
                    n_term[8] = mk(1'b0, c_d, r_e2_item.az);
                end else begin
                    n_pass    = 3'b000;
                    n_term[0] = mk(1'b0, c_nx, r_e2_item.ax);
                    n_term[1] = mk(1'b1, c_cy, r_e2_item.ay);
                    n_term[2] = mk(1'b1, r_e2_ex, r_e2_item.az);
                    n_term[3] = mk(1'b0, c_ny, r_e2_item.ax);
                    n_term[4] = mk(1'b0, c_cx, r_e2_item.ay);
                    n_term[5] = mk(1'b1, r_e2_ey, r_e2_item.az);
                    n_term[6] = mk(1'b0, c_nz, r_e2_item.ax);
                    n_term[8] = mk(1'b0, c_d, r_e2_item.az);
                end
            end
            default: begin
                n_pass = 3'b111;
            end
        endcase
    end

    // products
    logic                     r_p_valid;
    t_item                    r_p_item;
    logic [2:0]               r_p_pass;
    logic [8:0]               r_p_en;
    logic [8:0]               r_p_neg;
    logic signed [PROD_W-1:0] r_p_prod [0:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= r_e2_valid;
        end
        r_p_item <= r_e2_item;
        r_p_pass <= n_pass;
        for (int i = 0; i < 9; i++) begin
            r_p_en[i]   <= n_term[i].en;
            r_p_neg[i]  <= n_term[i].neg;
            r_p_prod[i] <= n_term[i].coef * n_term[i].vec;
        end
    end

    // rounding and sign of each term
    logic                     r_r_valid;
    t_item                    r_r_item;
    logic [2:0]               r_r_pass;
    logic signed [TERM_W-1:0] r_r_term [0:8];
    logic signed [PROD_W-1:0] n_rnd    [0:8];
    logic signed [TERM_W-1:0] n_mag    [0:8];

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n_rnd[i] = (r_p_prod[i] + RND) >>> NORM_FB;
            n_mag[i] = TERM_W'($signed(n_rnd[i][RND_W-1:0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else begin
            r_r_valid <= r_p_valid;
        end
        r_r_item <= r_p_item;
        r_r_pass <= r_p_pass;
        for (int i = 0; i < 9; i++) begin
            if (!r_p_en[i]) begin
                r_r_term[i] <= '0;
            end else if (r_p_neg[i]) begin
                r_r_term[i] <= -n_mag[i];
            end else begin
                r_r_term[i] <= n_mag[i];
            end
        end
    end

    // sum, clamp and output
    logic signed [SUM_W-1:0] n_sum [0:2];
    logic signed [VEC_W-1:0] n_res [0:2];
    logic signed [VEC_W-1:0] n_raw [0:2];
    logic [2:0]              n_clip;

    assign n_raw[0] = r_r_item.ax;
    assign n_raw[1] = r_r_item.ay;
    assign n_raw[2] = r_r_item.az;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_sum[j] = SUM_W'(r_r_term[3*j]) + SUM_W'(r_r_term[3*j+1])
                     + SUM_W'(r_r_term[3*j+2]);
            n_clip[j] = 1'b0;
            if (r_r_pass[j]) begin
                n_res[j] = n_raw[j];
            end else if (n_sum[j] > SAT_HI) begin
                n_res[j]  = SAT_HI[VEC_W-1:0];
                n_clip[j] = 1'b1;
            end else if (n_sum[j] < SAT_LO) begin
                n_res[j]  = SAT_LO[VEC_W-1:0];
                n_clip[j] = 1'b1;
            end else begin
                n_res[j] = n_sum[j][VEC_W-1:0];
            end
        end
    end

    logic                    r_o_valid;
    logic signed [VEC_W-1:0] r_o_x;
    logic signed [VEC_W-1:0] r_o_y;
    logic signed [VEC_W-1:0] r_o_z;
    logic                    r_o_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_r_valid;
        end
        r_o_x   <= n_res[0];
        r_o_y   <= n_res[1];
        r_o_z   <= n_res[2];
        r_o_sat <= |n_clip;
    end

    assign o_valid     = r_o_valid;
    assign o_out_x     = r_o_x;
    assign o_out_y     = r_o_y;
    assign o_out_z     = r_o_z;
    assign o_saturated = r_o_sat;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the normal frame vector rotator: directed table then random beats
module testbench;
    import nfvr_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               sat;
    } t_rot_res;

    typedef struct {
        t_dim        dim;
        logic [31:0] lim;
        t_item       it;
        logic        typed;
        t_rot_res    res;
    } t_table_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic               i_opcode;
    logic signed [31:0] i_vec_x, i_vec_y, i_vec_z;
    logic signed [31:0] i_norm_x, i_norm_y, i_norm_z;
    logic               o_valid;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;
    logic               o_saturated;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    t_cfg_idx           i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;

    logic               typed_en;
    t_rot_res           typed_res;

    t_dim               cur_dim = DIM_THREE;
    logic [30:0]        cur_lim = 31'd11;
    t_rot_res           rotated_q[$];
    t_table_row         rows[$];
    int                 errors = 0;
    t_dim               tb_dim = DIM_THREE;
    logic [31:0]        tb_lim = 32'd11;

    normal_frame_vector_rotator uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[normal_frame_vector_rotator] ERROR");
        $finish;
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic longint rnd_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return (p + 64'sd536870912) >>> 30;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v, inout logic f);
        if (v > 64'sd2147483647) begin
            f = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            f = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_rot_res predict_rotation(input t_item it, input t_dim dim,
                                                  input logic [30:0] lim);
        t_rot_res r;
        longint ax, ay, az, nx, ny, nz, rx, ry, rz, d, cx, cy, ex, ey;
        logic f;
        logic bk;
        ax = it.ax; ay = it.ay; az = it.az;
        nx = it.nx; ny = it.ny; nz = it.nz;
        bk = (it.op == OP_BACK);
        rx = ax; ry = ay; rz = az;
        f = 1'b0;
        case (dim)
            DIM_ONE: rx = rnd_mul(nx, ax);
            DIM_TWO: begin
                if (!bk) begin
                    rx = rnd_mul(nx, ax) + rnd_mul(ny, ay);
                    ry = -rnd_mul(ny, ax) + rnd_mul(nx, ay);
                end else begin
                    rx = rnd_mul(nx, ax) - rnd_mul(ny, ay);
                    ry = rnd_mul(ny, ax) + rnd_mul(nx, ay);
                end
            end
            DIM_THREE: begin
                d = int_sqrt(longint'(unsigned'(nx * nx)) + longint'(unsigned'(ny * ny)));
                if (d > longint'(lim)) begin
                    cx = (nx * (64'sd1 << 30)) / d;
                    cy = (ny * (64'sd1 << 30)) / d;
                    ex = rnd_mul(cx, nz);
                    ey = rnd_mul(cy, nz);
                    if (!bk) begin
                        rx = rnd_mul(nx, ax) + rnd_mul(ny, ay) + rnd_mul(nz, az);
                        ry = -rnd_mul(cy, ax) + rnd_mul(cx, ay);
                        rz = -rnd_mul(ex, ax) - rnd_mul(ey, ay) + rnd_mul(d, az);
                    end else begin
                        rx = rnd_mul(nx, ax) - rnd_mul(cy, ay) - rnd_mul(ex, az);
                        ry = rnd_mul(ny, ax) + rnd_mul(cx, ay) - rnd_mul(ey, az);
                        rz = rnd_mul(nz, ax) + rnd_mul(d, az);
                    end
                end else begin
                    rx = bk ? -rnd_mul(nz, az) : rnd_mul(nz, az);
                    rz = bk ? rnd_mul(nz, ax) : -rnd_mul(nz, ax);
                end
            end
            default: ;
        endcase
        r.x = (dim != DIM_NONE) ? clamp32(rx, f) : rx[31:0];
        r.y = (dim == DIM_TWO || dim == DIM_THREE) ? clamp32(ry, f) : ry[31:0];
        r.z = (dim == DIM_THREE) ? clamp32(rz, f) : rz[31:0];
        r.sat = f;
        return r;
    endfunction

    // config and start beats as the block sees them
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DIMENSION: cur_dim = t_dim'(i_cfg_data[1:0]);
                    CFG_LIMIT:     cur_lim = i_cfg_data[30:0];
                endcase
            end
            if (i_start && !o_busy) begin
                if (typed_en)
                    rotated_q.push_back(typed_res);
                else
                    rotated_q.push_back(predict_rotation(
                        '{op: t_op'(i_opcode), ax: i_vec_x, ay: i_vec_y, az: i_vec_z,
                          nx: i_norm_x, ny: i_norm_y, nz: i_norm_z}, cur_dim, cur_lim));
            end
        end
    end

    // result beats
    always @(posedge i_clk) begin
        t_rot_res e;
        if (i_rst_n && o_valid) begin
            if (rotated_q.size() == 0) begin
                report("result beat with nothing expected");
            end else begin
                e = rotated_q.pop_front();
                if (o_out_x !== e.x)
                    report($sformatf("out_x %h expected %h", o_out_x, e.x));
                if (o_out_y !== e.y)
                    report($sformatf("out_y %h expected %h", o_out_y, e.y));
                if (o_out_z !== e.z)
                    report($sformatf("out_z %h expected %h", o_out_z, e.z));
                if (o_saturated !== e.sat)
                    report($sformatf("saturated %b expected %b", o_saturated, e.sat));
            end
        end
    end

    task automatic wait_drained();
        while (rotated_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input t_dim dim, input logic [31:0] lim);
        i_start <= 1'b0;
        wait_drained();
        cfg_write(CFG_DIMENSION, {$urandom} & 32'hFFFFFFFC | 32'(dim));
        cfg_write(CFG_LIMIT, lim);
        tb_dim = dim;
        tb_lim = lim;
    endtask

    task automatic send_item(input t_item it, input logic typed, input t_rot_res res);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_opcode  <= it.op;
        i_vec_x   <= it.ax;
        i_vec_y   <= it.ay;
        i_vec_z   <= it.az;
        i_norm_x  <= it.nx;
        i_norm_y  <= it.ny;
        i_norm_z  <= it.nz;
        typed_en  <= typed;
        typed_res <= res;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic add_row(input t_dim dim, input logic [31:0] lim, input t_op op,
                           input logic [31:0] ax, ay, az, nx, ny, nz,
                           input logic typed, input logic [31:0] ex, ey, ez,
                           input logic es);
        t_table_row r;
        r.dim = dim;
        r.lim = lim;
        r.it = '{op: op, ax: ax, ay: ay, az: az, nx: nx, ny: ny, nz: nz};
        r.typed = typed;
        r.res = '{x: ex, y: ey, z: ez, sat: es};
        rows.push_back(r);
    endtask

    function automatic logic signed [31:0] rand_normal_comp(input real v);
        return $rtoi(v * 1073741823.0);
    endfunction

    function automatic t_item rand_item();
        t_item it;
        real a, b;
        it.op = t_op'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0) begin
            it.ax = $urandom;
            it.ay = $urandom;
            it.az = $urandom;
        end else begin
            it.ax = $signed($urandom) >>> $urandom_range(4, 20);
            it.ay = $signed($urandom) >>> $urandom_range(4, 20);
            it.az = $signed($urandom) >>> $urandom_range(4, 20);
        end
        case ($urandom_range(0, 5))
            0, 1: begin
                it.nx = $urandom;
                it.ny = $urandom;
                it.nz = $urandom;
            end
            2: begin
                // close to the z axis
                it.nx = $signed(32'($urandom_range(0, 31))) - 16;
                it.ny = $signed(32'($urandom_range(0, 31))) - 16;
                it.nz = $urandom_range(0, 1) ? 32'sh40000000 : -32'sh40000000;
            end
            default: begin
                a = $urandom_range(0, 62831) / 10000.0;
                b = $urandom_range(0, 31415) / 10000.0;
                it.nx = rand_normal_comp($cos(a) * $sin(b));
                it.ny = rand_normal_comp($sin(a) * $sin(b));
                it.nz = rand_normal_comp($cos(b));
            end
        endcase
        return it;
    endfunction

    initial begin
        t_rot_res none;
        t_item it;
        logic [31:0] lims [4];
        none = '{x: 0, y: 0, z: 0, sat: 0};
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_opcode = 1'b0;
        i_vec_x = 0; i_vec_y = 0; i_vec_z = 0;
        i_norm_x = 0; i_norm_y = 0; i_norm_z = 0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_DIMENSION;
        i_cfg_data = 0;
        typed_en = 1'b0;
        typed_res = none;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unit x normal leaves the vector alone
        add_row(DIM_THREE, 11, OP_FWD, 32'h10000, 32'h20000, 32'h30000,
                32'h40000000, 0, 0, 1, 32'h10000, 32'h20000, 32'h30000, 0);
        add_row(DIM_THREE, 11, OP_BACK, 32'h10000, 32'h20000, 32'h30000,
                32'h40000000, 0, 0, 1, 32'h10000, 32'h20000, 32'h30000, 0);
        // near the axis, then rows checked against predict_rotation
        add_row(DIM_THREE, 11, OP_FWD, 32'h10000, 32'h20000, 32'h30000,
                0, 0, 32'h40000000, 1, 32'h30000, 32'h20000, -32'sh10000, 0);
        add_row(DIM_THREE, 11, OP_BACK, 32'h10000, 32'h20000, 32'h30000,
                0, 0, 32'h40000000, 1, -32'sh30000, 32'h20000, 32'h10000, 0);
        add_row(DIM_THREE, 0, OP_FWD, 32'h10000, 32'h20000, 32'h30000,
                0, 0, 32'h40000000, 1, 32'h30000, 32'h20000, -32'sh10000, 0);
        add_row(DIM_THREE, 32'h40000000, OP_FWD, 32'h10000, 32'h20000, 32'h30000,
                32'h40000000, 0, 0, 1, 0, 32'h20000, 0, 0);
        add_row(DIM_THREE, 32'h40000000, OP_FWD, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 0);
        add_row(DIM_THREE, 11, OP_FWD, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0, 0);
        add_row(DIM_THREE, 11, OP_BACK, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0);
        add_row(DIM_THREE, 11, OP_BACK, 32'h12345678, 32'hFEDCBA98, 32'h0F0F0F0F,
                32'h2D413CCD, 32'h2D413CCD, 0, 0, 0, 0, 0, 0);
        // dimension zero passes all through
        add_row(DIM_NONE, 11, OP_FWD, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF,
                32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1,
                32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 0);
        add_row(DIM_NONE, 11, OP_BACK, 0, 32'h55555555, 32'hAAAAAAAA,
                0, 0, 0, 1, 0, 32'h55555555, 32'hAAAAAAAA, 0);
        // one dimension with clamps at both ends, then two dimensions
        add_row(DIM_ONE, 11, OP_FWD, 32'h80000000, 5, 6,
                32'h80000000, 0, 0, 1, 32'h7FFFFFFF, 5, 6, 1);
        add_row(DIM_ONE, 11, OP_BACK, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                32'h80000000, 0, 0, 1, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1);
        add_row(DIM_ONE, 11, OP_FWD, 32'h00030000, 7, 8,
                32'h40000000, 0, 0, 1, 32'h00030000, 7, 8, 0);
        add_row(DIM_TWO, 11, OP_FWD, 32'h10000, 32'h20000, 32'h30000,
                32'h40000000, 0, 0, 1, 32'h10000, 32'h20000, 32'h30000, 0);
        add_row(DIM_TWO, 11, OP_BACK, 32'h10000, 32'h20000, 32'h30000,
                0, 32'h40000000, 0, 1, -32'sh20000, 32'h10000, 32'h30000, 0);
        add_row(DIM_TWO, 11, OP_FWD, 32'h7FFFFFFF, 32'h7FFFFFFF, 0,
                32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0);
        add_row(DIM_TWO, 11, OP_BACK, 32'h80000000, 32'h7FFFFFFF, 0,
                32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0);

        foreach (rows[i]) begin
            if (rows[i].dim != tb_dim || rows[i].lim != tb_lim)
                set_config(rows[i].dim, rows[i].lim);
            send_item(rows[i].it, rows[i].typed, rows[i].res);
        end

        lims = '{0, 11, 32'h40000000, 32'hFFFFFFFF};
        for (int ph = 0; ph < 9; ph++) begin
            set_config(t_dim'(ph % 4), (ph < 4) ? lims[ph] :
                       ($urandom_range(0, 1) ? lims[$urandom_range(0, 3)] : $urandom));
            for (int n = 0; n < 50; n++) begin
                if (ph == 2 && n == 25) begin
                    i_start <= 1'b0;
                    while (rotated_q.size() != 0) @(posedge i_clk);
                end
                it = rand_item();
                send_item(it, 1'b0, none);
            end
        end
        i_start <= 1'b0;

        while (rotated_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (rotated_q.size() != 0)
            report("expected results left over");
        if (errors == 0)
            $display("[normal_frame_vector_rotator] OK");
        else
            $display("[normal_frame_vector_rotator] ERROR");
        $finish;
    end

endmodule
